FILE: hw/rtl/evt_pkg.sv
// ----------------------------------------------------------------------------
// evt_pkg: shared definitions of the vertex transform core
// Register layout and reset values, register indexes, the enable bundle of
// the rotation unit and the width growth of one plane rotation.
// ----------------------------------------------------------------------------
package evt_pkg;

	// Field widths of the configuration registers.
	localparam int TRIG_W          = 16;
	localparam int ROT_REG_W       = 2 * TRIG_W;
	localparam int VEC_REG_W       = 48;
	localparam int CFG_DATA_W      = 48;
	localparam int CFG_IDX_W       = 3;
	localparam int DEPTH_W         = 15;
	localparam int SCALE_W         = 16;
	localparam int SCALE_FRAC_BITS = 8;

	// Register stages from input transfer to output register.
	localparam int NUM_STAGES = 14;

	// Reset values: identity rotations, unit scale, no offset, depth 0.75.
	localparam logic [ROT_REG_W-1:0] ROT_RESET    = 32'h0000_4000;
	localparam logic [VEC_REG_W-1:0] SCALE_RESET  = 48'h0100_0100_0100;
	localparam logic [VEC_REG_W-1:0] OFFSET_RESET = 48'h0000_0000_0000;
	localparam logic [DEPTH_W-1:0]   DEPTH_RESET  = 15'd12288;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODEL_ROT_FIRST,
		REG_MODEL_ROT_SECOND,
		REG_MODEL_ROT_THIRD,
		REG_WORLD_ROT_FIRST,
		REG_WORLD_ROT_SECOND,
		REG_AXIS_SCALE,
		REG_TOTAL_OFFSET,
		REG_DEPTH_FACTOR
	} evt_reg_t;

	// Load enables of the two stages inside one rotation unit.
	typedef struct packed {
		logic mul;
		logic sum;
	} evt_rot_en_t;

	// Extra result bits of one plane rotation: the sum of two full products
	// is TRIG_W + 1 bits wider than the operand, then frac bits are dropped.
	function automatic int rot_grow(int frac);
		return (frac < TRIG_W + 1) ? (TRIG_W + 1 - frac) : 0;
	endfunction

endpackage

FILE: hw/rtl/evt_sat.sv
// ----------------------------------------------------------------------------
// evt_sat: signed saturation
// Clamps a wide signed value to a narrower signed range and flags a clamp.
// ----------------------------------------------------------------------------
module evt_sat #(
	parameter int IW = 24,
	parameter int OW = 16
) (
	input  logic signed [IW-1:0] val,
	output logic        [OW-1:0] res,
	output logic                 clip
);

	localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

	logic [IW-OW:0] upper;

	// The value fits when all bits from the output sign upward agree.
	assign upper = val[IW-1:OW-1];
	assign clip  = !((&upper) || !(|upper));
	assign res   = clip ? (val[IW-1] ? OUT_MIN : OUT_MAX) : val[OW-1:0];

endmodule

FILE: hw/rtl/evt_rot.sv
// ----------------------------------------------------------------------------
// evt_rot: two-stage plane rotation unit
// Maps (a, b) to (a*c - b*s, a*s + b*c) >> frac, rounding toward minus
// infinity. The first stage registers the four products, the second the
// shifted sums.
// ----------------------------------------------------------------------------
module evt_rot #(
	parameter int IW   = 16,
	parameter int FRAC = 14
) (
	input  logic                                         clk,
	input  evt_pkg::evt_rot_en_t                         en,
	input  logic signed [IW-1:0]                         a,
	input  logic signed [IW-1:0]                         b,
	input  logic        [evt_pkg::ROT_REG_W-1:0]         sc,
	output logic signed [IW+evt_pkg::rot_grow(FRAC)-1:0] na,
	output logic signed [IW+evt_pkg::rot_grow(FRAC)-1:0] nb
);

	import evt_pkg::*;

	localparam int PW = IW + TRIG_W;
	localparam int SW = PW + 1;
	localparam int OW = IW + rot_grow(FRAC);

	logic signed [TRIG_W-1:0] sin_v;
	logic signed [TRIG_W-1:0] cos_v;
	logic signed [PW-1:0]     ac_s1;
	logic signed [PW-1:0]     bs_s1;
	logic signed [PW-1:0]     as_s1;
	logic signed [PW-1:0]     bc_s1;
	logic signed [SW-1:0]     diff_a;
	logic signed [SW-1:0]     sum_b;
	logic signed [SW-1:0]     sh_a;
	logic signed [SW-1:0]     sh_b;
	logic signed [OW-1:0]     na_s2;
	logic signed [OW-1:0]     nb_s2;

	assign sin_v = sc[ROT_REG_W-1:TRIG_W];
	assign cos_v = sc[TRIG_W-1:0];

	// Product stage.
	always_ff @(posedge clk) begin
		if (en.mul) begin
			ac_s1 <= PW'(a) * PW'(cos_v);
			bs_s1 <= PW'(b) * PW'(sin_v);
			as_s1 <= PW'(a) * PW'(sin_v);
			bc_s1 <= PW'(b) * PW'(cos_v);
		end
	end

	// Sums are taken at full width; the arithmetic shift floors them.
	assign diff_a = SW'(ac_s1) - SW'(bs_s1);
	assign sum_b  = SW'(as_s1) + SW'(bc_s1);
	assign sh_a   = diff_a >>> FRAC;
	assign sh_b   = sum_b >>> FRAC;

	// Sum stage.
	always_ff @(posedge clk) begin
		if (en.sum) begin
			na_s2 <= sh_a[OW-1:0];
			nb_s2 <= sh_b[OW-1:0];
		end
	end

	assign na = na_s2;
	assign nb = nb_s2;

endmodule

FILE: hw/rtl/euler_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// euler_vertex_transform_core: pipelined fixed-point vertex transform
// Rotates, scales, offsets and projects one point per transfer (mode 1: model rotations only).
// ----------------------------------------------------------------------------
// The core accepts one point in every clock cycle while the output side does
// not stall; each result passes through every pipeline stage in order.
// The stages are the five plane rotations, each a product stage and
// a sum stage, plus the scale product, the offset add, the depth product and
// the final saturation register. Every stage advances on its own when the
// stage after it has room, so a stalled output fills empty stages before
// the input is held off. Configuration writes take effect at once and must
// only be issued while no point is in flight.
module euler_vertex_transform_core #(
	parameter int COORD_BITS     = 16,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input channel.
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic signed [COORD_BITS-1:0]     in_x,
	input  logic signed [COORD_BITS-1:0]     in_y,
	input  logic signed [COORD_BITS-1:0]     in_z,
	// Output channel.
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [COORD_BITS-1:0]     out_x,
	output logic signed [COORD_BITS-1:0]     out_y,
	output logic signed [COORD_BITS-1:0]     out_z,
	output logic                             clipped,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [evt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [evt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import evt_pkg::*;

	localparam int W   = COORD_BITS;
	localparam int F   = TRIG_FRAC_BITS;
	localparam int G   = rot_grow(F);
	localparam int W1  = W + G;
	localparam int W2  = W + 2 * G;
	localparam int W3  = W + 3 * G;
	localparam int SPW = W3 + SCALE_W;
	localparam int P   = SPW - SCALE_FRAC_BITS + 1;
	localparam int P1  = P + G;
	localparam int P2  = P + 2 * G;
	localparam int DPW = P2 + DEPTH_W + 1;
	localparam int MW  = 3 * W + 2;
	localparam int NS  = NUM_STAGES;

	localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [ROT_REG_W-1:0] mrot1_q;
	logic [ROT_REG_W-1:0] mrot2_q;
	logic [ROT_REG_W-1:0] mrot3_q;
	logic [ROT_REG_W-1:0] wrot1_q;
	logic [ROT_REG_W-1:0] wrot2_q;
	logic [VEC_REG_W-1:0] scale_q;
	logic [VEC_REG_W-1:0] offset_q;
	logic [DEPTH_W-1:0]   depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrot1_q  <= ROT_RESET;
			mrot2_q  <= ROT_RESET;
			mrot3_q  <= ROT_RESET;
			wrot1_q  <= ROT_RESET;
			wrot2_q  <= ROT_RESET;
			scale_q  <= SCALE_RESET;
			offset_q <= OFFSET_RESET;
			depth_q  <= DEPTH_RESET;
		end else if (cfg_we) begin
			unique case (evt_reg_t'(cfg_index))
				REG_MODEL_ROT_FIRST:  mrot1_q  <= cfg_data[ROT_REG_W-1:0];
				REG_MODEL_ROT_SECOND: mrot2_q  <= cfg_data[ROT_REG_W-1:0];
				REG_MODEL_ROT_THIRD:  mrot3_q  <= cfg_data[ROT_REG_W-1:0];
				REG_WORLD_ROT_FIRST:  wrot1_q  <= cfg_data[ROT_REG_W-1:0];
				REG_WORLD_ROT_SECOND: wrot2_q  <= cfg_data[ROT_REG_W-1:0];
				REG_AXIS_SCALE:       scale_q  <= cfg_data[VEC_REG_W-1:0];
				REG_TOTAL_OFFSET:     offset_q <= cfg_data[VEC_REG_W-1:0];
				REG_DEPTH_FACTOR:     depth_q  <= cfg_data[DEPTH_W-1:0];
			endcase
		end
	end

	// Per-axis scale and offset fields, and the depth factor as signed.
	logic signed [SCALE_W-1:0] scl_x, scl_y, scl_z;
	logic signed [SCALE_W-1:0] ofs_x, ofs_y, ofs_z;
	logic signed [DEPTH_W:0]   depth_s;

	assign scl_x   = scale_q[3*SCALE_W-1:2*SCALE_W];
	assign scl_y   = scale_q[2*SCALE_W-1:SCALE_W];
	assign scl_z   = scale_q[SCALE_W-1:0];
	assign ofs_x   = offset_q[3*SCALE_W-1:2*SCALE_W];
	assign ofs_y   = offset_q[2*SCALE_W-1:SCALE_W];
	assign ofs_z   = offset_q[SCALE_W-1:0];
	assign depth_s = {1'b0, depth_q};

	// ------------------------------------------------------------------
	// Pipeline flow control: a stage loads when it is empty or when the
	// stage after it loads in the same cycle.
	// ------------------------------------------------------------------
	logic [NS:1] vld_q;
	logic [NS:1] vld_nxt;
	logic [NS:1] stage_en;

	always_comb begin
		stage_en[NS] = !vld_q[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	assign vld_nxt = {vld_q[NS-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_nxt[k];
				end
			end
		end
	end

	assign in_ready  = stage_en[1];
	assign out_valid = vld_q[NS];

	// ------------------------------------------------------------------
	// Stages 1-6: model rotations in the xz, yz and xy planes.
	// ------------------------------------------------------------------
	logic signed [W1-1:0] x1, z1;
	logic signed [W2-1:0] y2, z2;
	logic signed [W3-1:0] x3, y3;
	logic signed [W-1:0]  y_s1, y_s2;
	logic signed [W1-1:0] x1_s3, x1_s4;
	logic signed [W2-1:0] z2_s5, z2_s6;
	logic                 mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6;

	evt_rot #(.IW(W), .FRAC(F)) u_mrot1 (
		.clk (clk),
		.en  ('{mul: stage_en[1], sum: stage_en[2]}),
		.a   (in_x),
		.b   (in_z),
		.sc  (mrot1_q),
		.na  (x1),
		.nb  (z1)
	);

	evt_rot #(.IW(W1), .FRAC(F)) u_mrot2 (
		.clk (clk),
		.en  ('{mul: stage_en[3], sum: stage_en[4]}),
		.a   (W1'(y_s2)),
		.b   (z1),
		.sc  (mrot2_q),
		.na  (y2),
		.nb  (z2)
	);

	evt_rot #(.IW(W2), .FRAC(F)) u_mrot3 (
		.clk (clk),
		.en  ('{mul: stage_en[5], sum: stage_en[6]}),
		.a   (W2'(x1_s4)),
		.b   (y2),
		.sc  (mrot3_q),
		.na  (x3),
		.nb  (y3)
	);

	// Coordinates and mode that ride beside the rotation units.
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			y_s1    <= in_y;
			mode_s1 <= mode;
		end
		if (stage_en[2]) begin
			y_s2    <= y_s1;
			mode_s2 <= mode_s1;
		end
		if (stage_en[3]) begin
			x1_s3   <= x1;
			mode_s3 <= mode_s2;
		end
		if (stage_en[4]) begin
			x1_s4   <= x1_s3;
			mode_s4 <= mode_s3;
		end
		if (stage_en[5]) begin
			z2_s5   <= z2;
			mode_s5 <= mode_s4;
		end
		if (stage_en[6]) begin
			z2_s6   <= z2_s5;
			mode_s6 <= mode_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: scale products, and the saturated model-only result that
	// is carried to the end for mode 1 points.
	// ------------------------------------------------------------------
	logic [W-1:0]          mx, my, mz;
	logic                  mclip_x, mclip_y, mclip_z;
	logic signed [SPW-1:0] px_s7, py_s7, pz_s7;
	logic [MW-1:0]         mdl_s7, mdl_s8, mdl_s9, mdl_s10, mdl_s11, mdl_s12, mdl_s13;

	evt_sat #(.IW(W3), .OW(W)) u_msat_x (.val(x3), .res(mx), .clip(mclip_x));
	evt_sat #(.IW(W3), .OW(W)) u_msat_y (.val(y3), .res(my), .clip(mclip_y));
	evt_sat #(.IW(W2), .OW(W)) u_msat_z (.val(z2_s6), .res(mz), .clip(mclip_z));

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			px_s7  <= SPW'(x3) * SPW'(scl_x);
			py_s7  <= SPW'(y3) * SPW'(scl_y);
			pz_s7  <= SPW'(z2_s6) * SPW'(scl_z);
			mdl_s7 <= {mode_s6, mclip_x | mclip_y | mclip_z, mx, my, mz};
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: drop the scale fraction and add the combined offset.
	// ------------------------------------------------------------------
	logic signed [P-1:0] qx_s8, qy_s8, qz_s8;

	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			qx_s8  <= P'(px_s7 >>> SCALE_FRAC_BITS) + P'(ofs_x);
			qy_s8  <= P'(py_s7 >>> SCALE_FRAC_BITS) + P'(ofs_y);
			qz_s8  <= P'(pz_s7 >>> SCALE_FRAC_BITS) + P'(ofs_z);
			mdl_s8 <= mdl_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stages 9-12: world rotations in the xz and yz planes.
	// ------------------------------------------------------------------
	logic signed [P1-1:0] x4, z4;
	logic signed [P2-1:0] y5, z5;
	logic signed [P-1:0]  qy_s9, qy_s10;
	logic signed [P1-1:0] x4_s11, x4_s12;

	evt_rot #(.IW(P), .FRAC(F)) u_wrot1 (
		.clk (clk),
		.en  ('{mul: stage_en[9], sum: stage_en[10]}),
		.a   (qx_s8),
		.b   (qz_s8),
		.sc  (wrot1_q),
		.na  (x4),
		.nb  (z4)
	);

	evt_rot #(.IW(P1), .FRAC(F)) u_wrot2 (
		.clk (clk),
		.en  ('{mul: stage_en[11], sum: stage_en[12]}),
		.a   (P1'(qy_s10)),
		.b   (z4),
		.sc  (wrot2_q),
		.na  (y5),
		.nb  (z5)
	);

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			qy_s9  <= qy_s8;
			mdl_s9 <= mdl_s8;
		end
		if (stage_en[10]) begin
			qy_s10  <= qy_s9;
			mdl_s10 <= mdl_s9;
		end
		if (stage_en[11]) begin
			x4_s11  <= x4;
			mdl_s11 <= mdl_s10;
		end
		if (stage_en[12]) begin
			x4_s12  <= x4_s11;
			mdl_s12 <= mdl_s11;
		end
	end

	// ------------------------------------------------------------------
	// Stage 13: depth product on z.
	// ------------------------------------------------------------------
	logic signed [DPW-1:0] dz_s13;
	logic signed [P1-1:0]  x4_s13;
	logic signed [P2-1:0]  y5_s13;

	always_ff @(posedge clk) begin
		if (stage_en[13]) begin
			dz_s13  <= DPW'(z5) * DPW'(depth_s);
			x4_s13  <= x4_s12;
			y5_s13  <= y5;
			mdl_s13 <= mdl_s12;
		end
	end

	// ------------------------------------------------------------------
	// Stage 14: drop the depth fraction, saturate, pick the result by
	// mode and hold it in the output register.
	// ------------------------------------------------------------------
	logic signed [DPW-1:0] zf;
	logic [W-1:0]          fx, fy, fz;
	logic                  fclip_x, fclip_y, fclip_z;
	logic [W-1:0]          out_x_s14, out_y_s14, out_z_s14;
	logic                  clip_s14;

	assign zf = dz_s13 >>> F;

	evt_sat #(.IW(P1),  .OW(W)) u_fsat_x (.val(x4_s13), .res(fx), .clip(fclip_x));
	evt_sat #(.IW(P2),  .OW(W)) u_fsat_y (.val(y5_s13), .res(fy), .clip(fclip_y));
	evt_sat #(.IW(DPW), .OW(W)) u_fsat_z (.val(zf), .res(fz), .clip(fclip_z));

	always_ff @(posedge clk) begin
		if (stage_en[14]) begin
			if (mdl_s13[MW-1]) begin
				out_x_s14 <= mdl_s13[3*W-1:2*W];
				out_y_s14 <= mdl_s13[2*W-1:W];
				out_z_s14 <= mdl_s13[W-1:0];
				clip_s14  <= mdl_s13[3*W];
			end else begin
				out_x_s14 <= fx;
				out_y_s14 <= fy;
				out_z_s14 <= fz;
				clip_s14  <= fclip_x | fclip_y | fclip_z;
			end
		end
	end

	assign out_x   = out_x_s14;
	assign out_y   = out_y_s14;
	assign out_z   = out_z_s14;
	assign clipped = clip_s14;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A clipped result has at least one coordinate at a range bound.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			out_x == COORD_MAX || out_x == COORD_MIN ||
			out_y == COORD_MAX || out_y == COORD_MIN ||
			out_z == COORD_MAX || out_z == COORD_MIN)
	else $error("clipped set with no saturated coordinate");

	// The input is held off only while the first stage is occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_q[1])
	else $error("input stalled with an empty first stage");

	// A full pipeline with a stalled output must hold off the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !out_ready |-> !in_ready)
	else $error("input accepted into a full stalled pipeline");

	// A stalled output stage keeps its item for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS] && !out_ready |=> vld_q[NS] && $stable(out_x_s14) && $stable(clip_s14))
	else $error("stalled result lost or changed");

endmodule

FILE: verif/tb_euler_vertex_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_vertex_transform_core: self-checking bench of the vertex transform
// Streams points through the core under random input gaps and output stalls.
// A local fixed-point predictor works out every transformed point from a
// shadow copy of the registers, and each output transfer is compared with
// the oldest prediction. Register settings change only while the core is idle.
// ----------------------------------------------------------------------------
module tb_euler_vertex_transform_core;
	import evt_pkg::*;

	localparam int COORD_W     = 16;
	localparam int TRIG_FRAC   = 14;
	localparam int SCALE_FRAC  = 8;
	localparam int PIPE_DEPTH  = 14;
	localparam int STALL_LIMIT = 4000;
	localparam int BATCH_SIZE  = 117;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               clip;
	} point_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [COORD_W-1:0]   in_x;
	logic [COORD_W-1:0]   in_y;
	logic [COORD_W-1:0]   in_z;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COORD_W-1:0]   out_x;
	logic [COORD_W-1:0]   out_y;
	logic [COORD_W-1:0]   out_z;
	logic                 clipped;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow registers, predicted points and run bookkeeping.
	logic [47:0]   reg_shadow [8];
	point_result_t pending_points [$];
	int            error_count   = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            quiet_cycles  = 0;

	euler_vertex_transform_core #(
		.COORD_BITS    (COORD_W),
		.TRIG_FRAC_BITS(TRIG_FRAC)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.in_x     (in_x),
		.in_y     (in_y),
		.in_z     (in_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z),
		.clipped  (clipped),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One plane rotation: (a, b) -> (a*c - b*s, a*s + b*c), floored.
	function automatic logic [127:0] plane_turn(longint a, longint b, logic [47:0] sc);
		longint s;
		longint c;
		longint na;
		longint nb;
		s  = longint'($signed(sc[31:16]));
		c  = longint'($signed(sc[15:0]));
		na = (a * c - b * s) >>> TRIG_FRAC;
		nb = (a * s + b * c) >>> TRIG_FRAC;
		return {na, nb};
	endfunction

	function automatic bit beyond_range(longint v);
		return (v > 32767) || (v < -32768);
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[COORD_W-1:0];
	endfunction

	// Expected transformed point under the current shadow registers.
	function automatic point_result_t transform_point(logic m, logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz);
		longint x;
		longint y;
		longint z;
		logic [47:0] sv;
		logic [47:0] ov;
		point_result_t r;
		x = longint'($signed(px));
		y = longint'($signed(py));
		z = longint'($signed(pz));
		{x, z} = plane_turn(x, z, reg_shadow[REG_MODEL_ROT_FIRST]);
		{y, z} = plane_turn(y, z, reg_shadow[REG_MODEL_ROT_SECOND]);
		{x, y} = plane_turn(x, y, reg_shadow[REG_MODEL_ROT_THIRD]);
		if (m == 1'b0) begin
			sv = reg_shadow[REG_AXIS_SCALE];
			ov = reg_shadow[REG_TOTAL_OFFSET];
			x = (x * longint'($signed(sv[47:32]))) >>> SCALE_FRAC;
			y = (y * longint'($signed(sv[31:16]))) >>> SCALE_FRAC;
			z = (z * longint'($signed(sv[15:0]))) >>> SCALE_FRAC;
			x = x + longint'($signed(ov[47:32]));
			y = y + longint'($signed(ov[31:16]));
			z = z + longint'($signed(ov[15:0]));
			{x, z} = plane_turn(x, z, reg_shadow[REG_WORLD_ROT_FIRST]);
			{y, z} = plane_turn(y, z, reg_shadow[REG_WORLD_ROT_SECOND]);
			z = (z * longint'(reg_shadow[REG_DEPTH_FACTOR][14:0])) >>> TRIG_FRAC;
		end
		r.x    = clamp_coord(x);
		r.y    = clamp_coord(y);
		r.z    = clamp_coord(z);
		r.clip = beyond_range(x) | beyond_range(y) | beyond_range(z);
		return r;
	endfunction

	// Random sine/cosine pair: mostly within +-1.0, sometimes any bits or a corner.
	function automatic logic [31:0] rand_trig_pair();
		logic [15:0] corners [5];
		int kind;
		corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000};
		kind = $urandom_range(99);
		if (kind < 60)
			return {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384)};
		if (kind < 85)
			return $urandom;
		return {corners[$urandom_range(4)], corners[$urandom_range(4)]};
	endfunction

	// Random packed three-axis Q8.8 vector, mostly within +-2.0.
	function automatic logic [47:0] rand_axis_vec();
		if ($urandom_range(99) < 70)
			return {16'($urandom_range(1024) - 512), 16'($urandom_range(1024) - 512),
				16'($urandom_range(1024) - 512)};
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Random coordinate: full range, small magnitude or a corner value.
	function automatic logic [COORD_W-1:0] rand_coord();
		logic [15:0] corners [5];
		int kind;
		corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
		kind = $urandom_range(99);
		if (kind < 50)
			return 16'($urandom);
		if (kind < 80)
			return 16'($urandom_range(2048) - 1024);
		return corners[$urandom_range(4)];
	endfunction

	// Output stalls.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Result checking against the oldest prediction, plus the watchdog.
	always @(posedge clk) begin
		point_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected result transfer: x=%h y=%h z=%h clipped=%b",
					out_x, out_y, out_z, clipped);
				error_count++;
			end else begin
				want = pending_points.pop_front();
				if (out_x !== want.x) begin
					$error("out_x mismatch: expected %h actual %h", want.x, out_x);
					error_count++;
				end
				if (out_y !== want.y) begin
					$error("out_y mismatch: expected %h actual %h", want.y, out_y);
					error_count++;
				end
				if (out_z !== want.z) begin
					$error("out_z mismatch: expected %h actual %h", want.z, out_z);
					error_count++;
				end
				if (clipped !== want.clip) begin
					$error("clipped mismatch: expected %b actual %b", want.clip, clipped);
					error_count++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Send one point; the prediction is queued at its input transfer.
	task automatic send_point(logic m, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
			logic [COORD_W-1:0] pz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		in_x     <= px;
		in_y     <= py;
		in_z     <= pz;
		do
			@(posedge clk);
		while (!in_ready);
		pending_points.push_back(transform_point(m, px, py, pz));
	endtask

	// Wait until every predicted point has come out, then let the pipe settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	// Write one register and mirror it; cfg_we is lowered by the caller.
	task automatic write_reg(evt_reg_t idx, logic [47:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_AXIS_SCALE, REG_TOTAL_OFFSET: reg_shadow[idx] = value;
			REG_DEPTH_FACTOR:                 reg_shadow[idx] = {33'd0, value[14:0]};
			default:                          reg_shadow[idx] = {16'd0, value[31:0]};
		endcase
	endtask

	// Program a whole register setting while the core is idle.
	task automatic program_regs(logic [31:0] mr1, logic [31:0] mr2, logic [31:0] mr3,
			logic [31:0] wr1, logic [31:0] wr2, logic [47:0] scale, logic [47:0] offset,
			logic [14:0] depth);
		write_reg(REG_MODEL_ROT_FIRST, {16'd0, mr1});
		write_reg(REG_MODEL_ROT_SECOND, {16'd0, mr2});
		write_reg(REG_MODEL_ROT_THIRD, {16'd0, mr3});
		write_reg(REG_WORLD_ROT_FIRST, {16'd0, wr1});
		write_reg(REG_WORLD_ROT_SECOND, {16'd0, wr2});
		write_reg(REG_AXIS_SCALE, scale);
		write_reg(REG_TOTAL_OFFSET, offset);
		write_reg(REG_DEPTH_FACTOR, {33'd0, depth});
		cfg_we <= 1'b0;
	endtask

	// Points through the reset setting: identity rotations, unit scale, depth 0.75.
	task automatic test_reset_values();
		send_point(1'b0, 16'h0000, 16'h0000, 16'h0000);
		send_point(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_point(1'b0, 16'h8000, 16'h8000, 16'h8000);
		send_point(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_point(1'b1, 16'h8000, 16'h7FFF, 16'h8000);
		send_point(1'b0, 16'h0100, 16'hFF00, 16'h7FFF);
		wait_drained();
	endtask

	// Corner settings: largest and smallest register values, then flooring of
	// odd negative values by half-scale and half-valued sine and cosine factors.
	task automatic test_extreme_settings();
		program_regs(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
			32'h7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 15'h7FFF);
		send_point(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_point(1'b0, 16'h8000, 16'h8000, 16'h8000);
		send_point(1'b0, 16'h0000, 16'h0000, 16'h0000);
		send_point(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_point(1'b0, 16'h0001, 16'hFFFF, 16'h0001);
		send_point(1'b1, 16'h0001, 16'hFFFF, 16'h0001);
		wait_drained();
		program_regs(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
			32'h8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 15'h0000);
		send_point(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_point(1'b0, 16'h8000, 16'h8000, 16'h8000);
		send_point(1'b0, 16'h0000, 16'h0000, 16'h0000);
		send_point(1'b1, 16'h8000, 16'h8000, 16'h8000);
		send_point(1'b0, 16'h0001, 16'hFFFF, 16'h0001);
		send_point(1'b1, 16'h0001, 16'hFFFF, 16'h0001);
		wait_drained();
		program_regs(32'h2000_2000, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000,
			32'h0000_4000, 48'h0080_0080_0080, 48'h0000_0000_0000, 15'h2000);
		send_point(1'b0, 16'hFFFF, 16'hFFFD, 16'hFFFB);
		send_point(1'b0, 16'h0001, 16'h0003, 16'h0005);
		send_point(1'b1, 16'hFFFF, 16'hFFFD, 16'hFFFB);
		send_point(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF);
		wait_drained();
	endtask

	// Random points under one idle profile; the first setting of each profile
	// is fixed and the rest are random.
	task automatic test_random_stream(int send_pct, int recv_pct, int corner_kind);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int setting = 0; setting < 4; setting++) begin
			if (setting == 0 && corner_kind == 0)
				program_regs(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
					32'h7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 15'h7FFF);
			else if (setting == 0 && corner_kind == 1)
				program_regs(32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
					32'h8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 15'h0000);
			else if (setting == 0)
				program_regs(32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000,
					32'h0000_4000, 48'h0100_0100_0100, 48'h0000_0000_0000, 15'd12288);
			else
				program_regs(rand_trig_pair(), rand_trig_pair(), rand_trig_pair(),
					rand_trig_pair(), rand_trig_pair(), rand_axis_vec(), rand_axis_vec(),
					15'($urandom));
			for (int n = 0; n < BATCH_SIZE; n++)
				send_point($urandom_range(99) < 25, rand_coord(), rand_coord(), rand_coord());
			wait_drained();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = 1'b0;
		in_x      = '0;
		in_y      = '0;
		in_z      = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		reg_shadow[REG_MODEL_ROT_FIRST]  = 48'h0000_0000_4000;
		reg_shadow[REG_MODEL_ROT_SECOND] = 48'h0000_0000_4000;
		reg_shadow[REG_MODEL_ROT_THIRD]  = 48'h0000_0000_4000;
		reg_shadow[REG_WORLD_ROT_FIRST]  = 48'h0000_0000_4000;
		reg_shadow[REG_WORLD_ROT_SECOND] = 48'h0000_0000_4000;
		reg_shadow[REG_AXIS_SCALE]       = 48'h0100_0100_0100;
		reg_shadow[REG_TOTAL_OFFSET]     = 48'h0000_0000_0000;
		reg_shadow[REG_DEPTH_FACTOR]     = 48'd12288;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 59;
		test_reset_values();
		test_extreme_settings();
		test_random_stream(31, 59, 0);
		test_random_stream(59, 31, 1);
		test_random_stream(0, 0, 2);

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
